FILE: hw/rtl/cvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSS value classifier package
// Shared types, recognizer phases and the keyword table of the classifier.
// ----------------------------------------------------------------------------
package cvc_pkg;

    localparam int KW_COUNT    = 31;
    localparam int KW_MAX_LEN  = 11;
    localparam int KW_TEXT_W   = 8 * KW_MAX_LEN;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] POS_LIMIT = 4'd12;

    // Keyword groups inside the alive vector.
    localparam logic [KW_COUNT-1:0] COLOR_MASK  = 31'h0001_FFFF;
    localparam logic [KW_COUNT-1:0] STYLE_MASK  = 31'h07FE_0000;
    localparam logic [KW_COUNT-1:0] WIDTH_MASK  = 31'h3800_0000;
    localparam logic [KW_COUNT-1:0] TRANSP_MASK = 31'h4000_0000;

    // Color names, then border styles, then widths, then transparent.
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        "maroon", "red", "orange", "yellow", "olive",
        "purple", "fuchsia", "white", "lime", "green",
        "navy", "blue", "aqua", "teal", "black",
        "silver", "gray",
        "none", "hidden", "dotted", "dashed", "solid",
        "double", "groove", "ridge", "inset", "outset",
        "thin", "medium", "thick",
        "transparent"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd3, 4'd6, 4'd6, 4'd5,
        4'd6, 4'd7, 4'd5, 4'd4, 4'd5,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd5,
        4'd6, 4'd4,
        4'd4, 4'd6, 4'd6, 4'd6, 4'd5,
        4'd6, 4'd6, 4'd5, 4'd5, 4'd6,
        4'd4, 4'd6, 4'd5,
        4'd11
    };

    typedef enum logic [2:0] {
        NUM_START, NUM_SIGN, NUM_INT, NUM_POINT, NUM_FRAC, NUM_DEAD
    } cvc_num_t;

    typedef enum logic [2:0] {
        UNIT_NONE, UNIT_E, UNIT_I, UNIT_CM, UNIT_P, UNIT_DONE, UNIT_DEAD
    } cvc_unit_t;

    typedef enum logic [1:0] {
        HEX_HASH, HEX_SEEN, HEX_DIGITS, HEX_DEAD
    } cvc_hex_t;

    typedef enum logic [3:0] {
        RGB_R, RGB_G, RGB_B, RGB_OPEN,
        RGB_RED_D0, RGB_RED_RUN, RGB_GRN_D0, RGB_GRN_RUN,
        RGB_BLU_D0, RGB_BLU_RUN, RGB_CLOSED, RGB_DEAD
    } cvc_rgb_t;

    // First member lands in the highest bit, so is_number is bit 0.
    typedef struct packed {
        logic is_border_color;
        logic is_border_width;
        logic is_border_style;
        logic is_color;
        logic is_length;
        logic is_number;
    } cvc_flags_t;

    typedef struct packed {
        logic       valid;
        cvc_flags_t flags;
    } cvc_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    // Byte at position pos of keyword k; zero past the keyword's end.
    function automatic logic [7:0] kw_byte(input int k, input logic [3:0] pos);
        logic [KW_TEXT_W-1:0] t;
        t = KW_TEXT[k] << (8 * (KW_MAX_LEN - int'(KW_LEN[k])));
        t = t << {pos, 3'b000};
        return t[KW_TEXT_W-1 -: 8];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/cvc_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSS value classifier front end
// Steps all recognizers by one character per beat and emits the six match
// flags on the last character of a string.
// ----------------------------------------------------------------------------
module cvc_scan
    import cvc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic [7:0]  in_char,
    input  wire logic        in_last,
    output cvc_result_t      result
);

    cvc_num_t             num_reg,  num_next;
    cvc_unit_t            unit_reg, unit_next;
    cvc_hex_t             hex_reg,  hex_next;
    cvc_rgb_t             rgb_reg,  rgb_next;
    logic [KW_COUNT-1:0]  kw_reg,   kw_next;
    logic [KW_COUNT-1:0]  kw_end;
    logic [3:0]           pos_reg,  pos_next;

    always_comb begin
        num_next = NUM_DEAD;
        case (num_reg)
            NUM_START: begin
                if (in_char == "+" || in_char == "-") num_next = NUM_SIGN;
                else if (is_digit(in_char))           num_next = NUM_INT;
            end
            NUM_SIGN: begin
                if (is_digit(in_char)) num_next = NUM_INT;
            end
            NUM_INT: begin
                if (is_digit(in_char))    num_next = NUM_INT;
                else if (in_char == ".")  num_next = NUM_POINT;
            end
            NUM_POINT, NUM_FRAC: begin
                if (is_digit(in_char)) num_next = NUM_FRAC;
            end
            default: num_next = NUM_DEAD;
        endcase
    end

    // The unit starts on the first character after a complete number.
    always_comb begin
        unit_next = UNIT_DEAD;
        case (unit_reg)
            UNIT_NONE: begin
                if (!(num_reg == NUM_INT || num_reg == NUM_FRAC) || is_digit(in_char)
                        || (num_reg == NUM_INT && in_char == "."))
                    unit_next = UNIT_NONE;
                else if (in_char == "e")                    unit_next = UNIT_E;
                else if (in_char == "i")                    unit_next = UNIT_I;
                else if (in_char == "c" || in_char == "m")  unit_next = UNIT_CM;
                else if (in_char == "p")                    unit_next = UNIT_P;
                else if (in_char == "%")                    unit_next = UNIT_DONE;
            end
            UNIT_E: begin
                if (in_char == "m" || in_char == "x") unit_next = UNIT_DONE;
            end
            UNIT_I: begin
                if (in_char == "n") unit_next = UNIT_DONE;
            end
            UNIT_CM: begin
                if (in_char == "m") unit_next = UNIT_DONE;
            end
            UNIT_P: begin
                if (in_char == "t" || in_char == "c" || in_char == "x")
                    unit_next = UNIT_DONE;
            end
            default: unit_next = UNIT_DEAD;
        endcase
    end

    always_comb begin
        hex_next = HEX_DEAD;
        case (hex_reg)
            HEX_HASH: begin
                if (in_char == "#") hex_next = HEX_SEEN;
            end
            HEX_SEEN, HEX_DIGITS: begin
                if (is_hex(in_char)) hex_next = HEX_DIGITS;
            end
            default: hex_next = HEX_DEAD;
        endcase
    end

    always_comb begin
        rgb_next = RGB_DEAD;
        case (rgb_reg)
            RGB_R:    if (in_char == "r") rgb_next = RGB_G;
            RGB_G:    if (in_char == "g") rgb_next = RGB_B;
            RGB_B:    if (in_char == "b") rgb_next = RGB_OPEN;
            RGB_OPEN: if (in_char == "(") rgb_next = RGB_RED_D0;
            RGB_RED_D0, RGB_RED_RUN: begin
                if (is_digit(in_char))                          rgb_next = RGB_RED_RUN;
                else if (rgb_reg == RGB_RED_RUN && in_char == ",") rgb_next = RGB_GRN_D0;
            end
            RGB_GRN_D0, RGB_GRN_RUN: begin
                if (is_digit(in_char))                          rgb_next = RGB_GRN_RUN;
                else if (rgb_reg == RGB_GRN_RUN && in_char == ",") rgb_next = RGB_BLU_D0;
            end
            RGB_BLU_D0, RGB_BLU_RUN: begin
                if (is_digit(in_char))                          rgb_next = RGB_BLU_RUN;
                else if (rgb_reg == RGB_BLU_RUN && in_char == ")") rgb_next = RGB_CLOSED;
            end
            default: rgb_next = RGB_DEAD;
        endcase
    end

    // Each keyword compares its own byte at the current position.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_next[k] = kw_reg[k] && (pos_reg < KW_LEN[k]) && (kw_byte(k, pos_reg) == in_char);
            kw_end[k]  = kw_next[k] && ((pos_reg + 4'd1) == KW_LEN[k]);
        end
        pos_next = (pos_reg < POS_LIMIT) ? pos_reg + 4'd1 : POS_LIMIT;
    end

    always_comb begin
        result.valid                 = in_valid && in_last;
        result.flags.is_number       = (num_next == NUM_INT) || (num_next == NUM_FRAC);
        result.flags.is_length       = (unit_next == UNIT_DONE);
        result.flags.is_color        = (hex_next == HEX_DIGITS) || (rgb_next == RGB_CLOSED)
                                       || ((kw_end & COLOR_MASK) != '0);
        result.flags.is_border_style = (kw_end & STYLE_MASK) != '0;
        result.flags.is_border_width = ((kw_end & WIDTH_MASK) != '0) || result.flags.is_length;
        result.flags.is_border_color = ((kw_end & TRANSP_MASK) != '0) || result.flags.is_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_valid && in_last)) begin
            num_reg  <= NUM_START;
            unit_reg <= UNIT_NONE;
            hex_reg  <= HEX_HASH;
            rgb_reg  <= RGB_R;
            kw_reg   <= '1;
            pos_reg  <= '0;
        end else if (in_valid) begin
            num_reg  <= num_next;
            unit_reg <= unit_next;
            hex_reg  <= hex_next;
            rgb_reg  <= rgb_next;
            kw_reg   <= kw_next;
            pos_reg  <= pos_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cvc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSS value classifier result queue
// Short queue that holds finished flag sets until the result side takes them.
// ----------------------------------------------------------------------------
module cvc_queue
    import cvc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cvc_result_t push,
    output logic             full,
    output logic             out_valid,
    input  wire logic        out_ready,
    output cvc_flags_t       out_flags
);

    cvc_flags_t              store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg,  count_next;
    logic                    do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_flags = store_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push.valid && !full;
        do_pop      = out_valid && out_ready;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push.flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/css_value_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CSS value classifier
// Classifies a CSS value string, streamed one character per beat, as number,
// length, color, border style, border width and border color.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one ASCII character of the value string per beat
//   in s_tdata; s_tlast marks the last character of the string. Each string
//   produces exactly one beat on the m_ channel, whose m_tdata bits 5:0 are
//   the six match flags. Strings follow one another with no gap.
//   The scanner takes one character every cycle; all recognizers advance one
//   small state step per character, so throughput is one character per cycle
//   as long as the result queue has room.
//   The flags of a string appear on m_tvalid in the cycle after its last
//   character is accepted, when the queue was empty.
//   A four-entry queue sits between scanner and output. When the receiver
//   stalls m_tready, results pile up there; the scanner keeps taking
//   characters until four results wait, then s_tready drops until one beat
//   leaves the queue.
//   Reset (aresetn low, synchronous) returns every recognizer to its start
//   state and empties the queue; a partly received string is dropped.
// ----------------------------------------------------------------------------
module css_value_classifier
    import cvc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // is_final
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] is_number, [1] is_length, [2] is_color,
                                        // [3] is_border_style, [4] is_border_width,
                                        // [5] is_border_color, [7:6] zero
);

    cvc_result_t   scan_result;
    cvc_flags_t    queue_flags;
    logic          queue_full;
    logic          in_beat;

    // Input is held off only while the result queue is full, so a final
    // character always finds a free slot.
    assign s_tready = !queue_full;
    assign in_beat  = s_tvalid && s_tready;

    cvc_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_beat),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .result   (scan_result)
    );

    cvc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (scan_result),
        .full      (queue_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_flags (queue_flags)
    );

    // Flag struct is packed with is_number in bit 0.
    assign m_tdata = {2'b00, queue_flags};

endmodule
`default_nettype wire

FILE: sim/cvc_flag_checker.sv
// ----------------------------------------------------------------------------
// CSS value classifier flag checker
// Follows every accepted character beat, predicts the six match flags of
// each string and compares them with the result beats as they leave.
// ----------------------------------------------------------------------------
module cvc_flag_checker
    import cvc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    output int         error_count,
    output int         flags_owed
);

    // Keyword groups: color names, border styles, widths, transparent.
    localparam logic [30:0] COLOR_KW  = 31'h0001_FFFF;
    localparam logic [30:0] STYLE_KW  = 31'h07FE_0000;
    localparam logic [30:0] WIDTH_KW  = 31'h3800_0000;
    localparam logic [30:0] TRANSP_KW = 31'h4000_0000;
    localparam logic [3:0]  POS_STOP  = 4'd12;

    string kw_word [31] = '{
        "maroon", "red", "orange", "yellow", "olive", "purple", "fuchsia",
        "white", "lime", "green", "navy", "blue", "aqua", "teal", "black",
        "silver", "gray",
        "none", "hidden", "dotted", "dashed", "solid", "double", "groove",
        "ridge", "inset", "outset",
        "thin", "medium", "thick",
        "transparent"
    };

    cvc_num_t    num_st;
    cvc_unit_t   unit_st;
    cvc_hex_t    hex_st;
    cvc_rgb_t    rgb_st;
    logic [30:0] kw_live;
    logic [3:0]  pos_cnt;
    cvc_flags_t  flags_due [$];
    int          errs = 0;
    int          owed = 0;

    assign error_count = errs;
    assign flags_owed  = owed;

    function automatic logic dec_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic hex_char(input logic [7:0] c);
        return dec_char(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic cvc_num_t num_step(input cvc_num_t p, input logic [7:0] c);
        case (p)
            NUM_START: begin
                if (c == "+" || c == "-") return NUM_SIGN;
                return dec_char(c) ? NUM_INT : NUM_DEAD;
            end
            NUM_SIGN:  return dec_char(c) ? NUM_INT : NUM_DEAD;
            NUM_INT: begin
                if (dec_char(c)) return NUM_INT;
                return (c == ".") ? NUM_POINT : NUM_DEAD;
            end
            NUM_POINT, NUM_FRAC: return dec_char(c) ? NUM_FRAC : NUM_DEAD;
            default:   return NUM_DEAD;
        endcase
    endfunction

    // The unit starts only right after a complete number.
    function automatic cvc_unit_t unit_step(input cvc_unit_t u, input cvc_num_t p,
                                            input logic [7:0] c);
        case (u)
            UNIT_NONE: begin
                if (!(p == NUM_INT || p == NUM_FRAC) || dec_char(c) ||
                    (p == NUM_INT && c == "."))
                    return UNIT_NONE;
                if (c == "e") return UNIT_E;
                if (c == "i") return UNIT_I;
                if (c == "c" || c == "m") return UNIT_CM;
                if (c == "p") return UNIT_P;
                if (c == "%") return UNIT_DONE;
                return UNIT_DEAD;
            end
            UNIT_E:  return (c == "m" || c == "x") ? UNIT_DONE : UNIT_DEAD;
            UNIT_I:  return (c == "n") ? UNIT_DONE : UNIT_DEAD;
            UNIT_CM: return (c == "m") ? UNIT_DONE : UNIT_DEAD;
            UNIT_P:  return (c == "t" || c == "c" || c == "x") ? UNIT_DONE : UNIT_DEAD;
            default: return UNIT_DEAD;
        endcase
    endfunction

    function automatic cvc_hex_t hex_step(input cvc_hex_t h, input logic [7:0] c);
        if (h == HEX_HASH) return (c == "#") ? HEX_SEEN : HEX_DEAD;
        if (h == HEX_SEEN || h == HEX_DIGITS) return hex_char(c) ? HEX_DIGITS : HEX_DEAD;
        return HEX_DEAD;
    endfunction

    function automatic cvc_rgb_t rgb_step(input cvc_rgb_t r, input logic [7:0] c);
        case (r)
            RGB_R:    return (c == "r") ? RGB_G : RGB_DEAD;
            RGB_G:    return (c == "g") ? RGB_B : RGB_DEAD;
            RGB_B:    return (c == "b") ? RGB_OPEN : RGB_DEAD;
            RGB_OPEN: return (c == "(") ? RGB_RED_D0 : RGB_DEAD;
            RGB_RED_D0, RGB_GRN_D0, RGB_BLU_D0:
                return dec_char(c) ? cvc_rgb_t'(r + 4'd1) : RGB_DEAD;
            RGB_RED_RUN, RGB_GRN_RUN: begin
                if (dec_char(c)) return r;
                return (c == ",") ? cvc_rgb_t'(r + 4'd1) : RGB_DEAD;
            end
            RGB_BLU_RUN: begin
                if (dec_char(c)) return RGB_BLU_RUN;
                return (c == ")") ? RGB_CLOSED : RGB_DEAD;
            end
            default:  return RGB_DEAD;
        endcase
    endfunction

    task automatic restart_scan();
        num_st  = NUM_START;
        unit_st = UNIT_NONE;
        hex_st  = HEX_HASH;
        rgb_st  = RGB_R;
        kw_live = '1;
        pos_cnt = '0;
    endtask

    // Advances every recognizer by one character; the last character of a
    // string queues the flags it ends with and restarts the scan.
    task automatic scan_char(input logic [7:0] c, input logic last);
        logic [30:0] live_nxt;
        logic [30:0] ended;
        cvc_flags_t  f;
        live_nxt = '0;
        ended    = '0;
        unit_st  = unit_step(unit_st, num_st, c);
        num_st   = num_step(num_st, c);
        hex_st   = hex_step(hex_st, c);
        rgb_st   = rgb_step(rgb_st, c);
        for (int k = 0; k < 31; k++) begin
            if (kw_live[k] && pos_cnt < kw_word[k].len() && kw_word[k][pos_cnt] == c) begin
                live_nxt[k] = 1'b1;
                if (int'(pos_cnt) + 1 == kw_word[k].len())
                    ended[k] = 1'b1;
            end
        end
        kw_live = live_nxt;
        pos_cnt = (pos_cnt < POS_STOP) ? pos_cnt + 4'd1 : POS_STOP;
        if (last) begin
            f.is_number       = (num_st == NUM_INT) || (num_st == NUM_FRAC);
            f.is_length       = (unit_st == UNIT_DONE);
            f.is_color        = (hex_st == HEX_DIGITS) || (rgb_st == RGB_CLOSED) ||
                                |(ended & COLOR_KW);
            f.is_border_style = |(ended & STYLE_KW);
            f.is_border_width = |(ended & WIDTH_KW) || f.is_length;
            f.is_border_color = |(ended & TRANSP_KW) || f.is_color;
            flags_due.push_back(f);
            restart_scan();
        end
    endtask

    task automatic flag_error(input string msg);
        $display("%0t: flag mismatch: %s", $realtime, msg);
        errs++;
    endtask

    task automatic check_flag(input string name, input logic got, input logic want);
        if (got !== want)
            flag_error($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    task automatic check_result(input logic [7:0] d);
        cvc_flags_t want;
        cvc_flags_t got;
        if (flags_due.size() == 0) begin
            flag_error($sformatf("result beat 0x%02h with no string pending", d));
        end else begin
            want = flags_due.pop_front();
            got  = cvc_flags_t'(d[5:0]);
            check_flag("is_number",       got.is_number,       want.is_number);
            check_flag("is_length",       got.is_length,       want.is_length);
            check_flag("is_color",        got.is_color,        want.is_color);
            check_flag("is_border_style", got.is_border_style, want.is_border_style);
            check_flag("is_border_width", got.is_border_width, want.is_border_width);
            check_flag("is_border_color", got.is_border_color, want.is_border_color);
            if (d[7:6] !== 2'b00)
                flag_error($sformatf("padding bits are %b", d[7:6]));
        end
    endtask

    // Results leave only after their last character has been pushed into the
    // registered result queue, so the pop comes before the push within one edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_scan();
            flags_due.delete();
            owed <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                scan_char(s_tdata, s_tlast);
            owed <= flags_due.size();
        end
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// CSS value classifier testbench
// Streams CSS value strings into the classifier, one character per beat,
// under three patterns of sender and receiver stalls, and lets the flag
// checker compare every result beat with its own prediction.
// ----------------------------------------------------------------------------
module tb;
    import cvc_pkg::*;

    // Characters per stall pattern in the random part.
    localparam int PHASE_CHARS = 270;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic       s_tlast  = 1'b0;    // is_final
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [5:0] the six match flags, [7:6] zero

    int error_count;
    int flags_owed;

    // Stall odds in percent; the stimulus changes them between phases.
    int send_gap_pct = 6;
    int recv_gap_pct = 60;

    // The string being built, one byte per entry.
    logic [7:0] css_text [$];
    int         chars_sent;

    // Bytes that drive the recognizers somewhere interesting.
    string near_alpha = "0123456789.+-#%(),abcdefghiklmnoprstuvwxyABCF ";

    always #5 aclk = ~aclk;

    css_value_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cvc_flag_checker u_flag_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .flags_owed  (flags_owed)
    );

    // The receiver stalls at random; inputs only move on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Safety net in case the block hangs; the slowest correct run needs a
    // small fraction of this.
    initial begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Offers one character beat, with random idle cycles in front of it, and
    // returns at the falling edge after the beat was taken. The valid line
    // is written once per falling edge, so back-to-back beats keep it high.
    task automatic send_beat(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < css_text.size(); i++)
            send_beat(css_text[i], i == css_text.size() - 1);
    endtask

    task automatic send_literal(input string t);
        css_text.delete();
        for (int i = 0; i < t.len(); i++)
            css_text.push_back(t[i]);
        send_text();
    endtask

    task automatic add_char(input string t);
        for (int i = 0; i < t.len(); i++)
            css_text.push_back(t[i]);
    endtask

    // Digit runs are mostly short, now and then longer than any keyword.
    task automatic add_digits();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
        repeat (n) css_text.push_back(8'($urandom_range("0", "9")));
    endtask

    task automatic add_number();
        case ($urandom_range(3))
            0: add_char("+");
            1: add_char("-");
            default: ;
        endcase
        add_digits();
        if ($urandom_range(1)) begin
            add_char(".");
            add_digits();
        end
    endtask

    task automatic add_unit();
        case ($urandom_range(8))
            0: add_char("em");
            1: add_char("ex");
            2: add_char("in");
            3: add_char("cm");
            4: add_char("mm");
            5: add_char("pt");
            6: add_char("pc");
            7: add_char("px");
            default: add_char("%");
        endcase
    endtask

    task automatic add_hex_color();
        string hexset;
        hexset = "0123456789abcdefABCDEF";
        add_char("#");
        repeat ($urandom_range(1, 8))
            css_text.push_back(hexset[$urandom_range(hexset.len() - 1)]);
    endtask

    task automatic add_rgb();
        add_char("rgb(");
        add_digits();
        add_char(",");
        add_digits();
        add_char(",");
        add_digits();
        add_char(")");
    endtask

    // Keyword bytes come from the package table, first character in the
    // highest used byte of each entry.
    task automatic add_keyword();
        int k;
        int n;
        k = $urandom_range(KW_COUNT - 1);
        n = int'(KW_LEN[k]);
        for (int i = 0; i < n; i++)
            css_text.push_back(KW_TEXT[k][8 * (n - 1 - i) +: 8]);
    endtask

    function automatic logic [7:0] any_byte();
        if ($urandom_range(1))
            return 8'($urandom_range(1, 255));
        return near_alpha[$urandom_range(near_alpha.len() - 1)];
    endfunction

    // Breaks a well-formed string in one place.
    task automatic mangle();
        case ($urandom_range(3))
            0: css_text[$urandom_range(css_text.size() - 1)] = any_byte();
            1: if (css_text.size() > 1) void'(css_text.pop_back());
            2: css_text.push_back(any_byte());
            default: css_text.push_front(any_byte());
        endcase
    endtask

    task automatic build_wellformed();
        case ($urandom_range(5))
            0: add_number();
            1, 2: begin
                add_number();
                add_unit();
            end
            3: add_hex_color();
            4: add_rgb();
            default: add_keyword();
        endcase
    endtask

    // Mostly well-formed strings with random content, some broken ones and
    // some noise, which includes bytes above the ASCII range and strings
    // longer than the keyword window.
    task automatic build_random_text();
        int pick;
        css_text.delete();
        pick = $urandom_range(99);
        if (pick < 78) begin
            build_wellformed();
        end else if (pick < 90) begin
            build_wellformed();
            mangle();
        end else begin
            repeat ($urandom_range(1, 16)) css_text.push_back(any_byte());
        end
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct);
        int start;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        start = chars_sent;
        while (chars_sent - start < PHASE_CHARS) begin
            build_random_text();
            send_text();
        end
    endtask

    initial begin
        chars_sent = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed strings: number, signed fraction, percent length, hex
        // color, rgb triple, color name, width keyword, and the character codes
        // 0x01 and 0xFF on their own.
        send_literal("0");
        send_literal("-1.5");
        send_literal("7%");
        send_literal("#fA9");
        send_literal("rgb(0,9,7)");
        send_literal("red");
        send_literal("thick");
        send_beat(8'h01, 1'b1);
        send_beat(8'hFF, 1'b1);

        run_random_phase(6, 60);
        run_random_phase(60, 6);
        run_random_phase(0, 0);
        s_tvalid <= 1'b0;

        // Drain every owed result, then keep the clock running so that any stray
        // beat shows.
        while (flags_owed != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);

        if (error_count == 0 && flags_owed == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
